@@ src/rle_pkg.sv @@
// ----------------------------------------------------------------------------
// rle_pkg: shared types and constants of the bitmap run-length encoder
// Code word layout, queue sizing and the request passed from front to queue.
// ----------------------------------------------------------------------------
package rle_pkg;

	localparam int PIXEL_W     = 8;
	localparam int LEN_W       = 7;
	localparam int CODE_W      = LEN_W + 1;
	localparam int MAX_RUN_DEF = 127;

	// Code queue: power of two, room for two codes per pixel plus slack
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	typedef struct packed {
		logic              run_bit;
		logic [LEN_W-1:0]  run_len;
		logic              eoi;
	} code_t;

	// Up to two codes per pixel; slot 1 is only used when slot 0 is
	typedef struct packed {
		logic  wr0;
		logic  wr1;
		code_t c0;
		code_t c1;
	} queue_push_t;

endpackage

@@ src/rle_front.sv @@
// ----------------------------------------------------------------------------
// rle_front: pixel classifier
// Holds the open run and turns each accepted pixel into zero, one or two codes.
// ----------------------------------------------------------------------------
module rle_front #(
	parameter int MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	input  logic [rle_pkg::PIXEL_W-1:0]  pixel,
	input  logic                         last_pixel,
	input  logic                         room,
	output logic                         pixel_stall,
	output rle_pkg::queue_push_t         push
);
	import rle_pkg::*;

	logic             bit_q;
	logic [LEN_W-1:0] len_q;

	logic             accept;
	logic             pix_bit;
	logic             change;
	logic [LEN_W-1:0] base_len;
	logic             run_bit;
	logic [LEN_W-1:0] new_len;
	logic             close;
	code_t            old_code;
	code_t            cur_code;

	assign pixel_stall = !room;
	assign accept      = pixel_valid && room;

	assign pix_bit  = |pixel;
	assign change   = (len_q != '0) && (pix_bit != bit_q);
	assign base_len = change ? '0 : len_q;
	assign run_bit  = (base_len == '0) ? pix_bit : bit_q;
	assign new_len  = base_len + LEN_W'(1);
	assign close    = (new_len >= LEN_W'(MAX_RUN)) || last_pixel;

	assign old_code = '{run_bit: bit_q, run_len: len_q, eoi: 1'b0};
	assign cur_code = '{run_bit: run_bit, run_len: new_len, eoi: last_pixel};

	always_comb begin
		push.wr0 = accept && (change || close);
		push.wr1 = accept && change && close;
		push.c0  = change ? old_code : cur_code;
		push.c1  = cur_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
			len_q <= '0;
		end else if (accept) begin
			bit_q <= run_bit;
			len_q <= close ? '0 : new_len;
		end
	end

	// An open run never reaches the limit without having been closed
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q < LEN_W'(MAX_RUN))
		else $error("open run at or beyond limit");

endmodule

@@ src/rle_queue.sv @@
// ----------------------------------------------------------------------------
// rle_queue: code queue
// Small circular buffer taking up to two codes a cycle and giving one.
// ----------------------------------------------------------------------------
module rle_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rle_pkg::queue_push_t  push,
	input  logic                  pop,
	output logic                  room,
	output logic                  not_empty,
	output rle_pkg::code_t        head
);
	import rle_pkg::*;

	code_t             mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_ptr_nx;

	assign room      = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem[rd_ptr_q];
	assign wr_ptr_nx = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.wr0) begin
			mem[wr_ptr_q] <= push.c0;
		end
		if (push.wr1) begin
			mem[wr_ptr_nx] <= push.c1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.wr0) + QPTR_W'(push.wr1);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push.wr0) + QCNT_W'(push.wr1) - QCNT_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("code queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty code queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		push.wr1 |-> (push.wr0 && room))
		else $error("second code pushed without first or without room");

endmodule

@@ src/rle_back.sv @@
// ----------------------------------------------------------------------------
// rle_back: code output stage
// Moves the queue head into the output register whenever that register frees.
// ----------------------------------------------------------------------------
module rle_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         not_empty,
	input  rle_pkg::code_t               head,
	output logic                         pop,
	input  logic                         code_stall,
	output logic                         code_valid,
	output logic [rle_pkg::CODE_W-1:0]   code_byte,
	output logic                         end_of_image
);
	import rle_pkg::*;

	logic  valid_q;
	code_t out_q;

	assign pop          = not_empty && (!valid_q || !code_stall);
	assign code_valid   = valid_q;
	assign code_byte    = {out_q.run_bit, out_q.run_len};
	assign end_of_image = out_q.eoi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !code_stall) begin
			valid_q <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	// Every code carries a run of at least one pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (out_q.run_len != '0))
		else $error("empty run on output");

endmodule

@@ src/bitmap_run_length_encoder.sv @@
// ----------------------------------------------------------------------------
// bitmap_run_length_encoder: run-length coder for glyph bitmaps
// Turns a pixel stream into code bytes of run bit and run length 1..MAX_RUN.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------
//  pixel   | pixel_valid / pixel_stall | pixel[7:0], last_pixel
//  code    | code_valid / code_stall   | code_byte[7:0], end_of_image
//
//  Cycles: one pixel request per clock while pixel_stall is low; a pixel yields 0, 1 or 2 codes.
//  Codes leave one per clock while code_stall is low, from a registered output;
//  each passes through the four-entry code queue and then the output register.
//  pixel_stall rises while the queue has room for fewer than two codes.
//  Reset (arst_n low) discards any open run without a code and empties the queue.
//  A stall on the code side holds the output code and backs up into the queue.
//
module bitmap_run_length_encoder #(
	parameter int MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  logic [rle_pkg::PIXEL_W-1:0]  pixel,
	input  logic                         last_pixel,
	output logic                         code_valid,
	input  logic                         code_stall,
	output logic [rle_pkg::CODE_W-1:0]   code_byte,
	output logic                         end_of_image
);
	import rle_pkg::*;

	queue_push_t push;
	logic        room;
	logic        not_empty;
	logic        pop;
	code_t       head;

	// Front: classify each pixel request against the open run
	rle_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.last_pixel  (last_pixel),
		.room        (room),
		.pixel_stall (pixel_stall),
		.push        (push)
	);

	// Queue: decouple the two sides so each may stall on its own
	rle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (not_empty),
		.head      (head)
	);

	// Back: hold one code in the output register until taken
	rle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.code_stall   (code_stall),
		.code_valid   (code_valid),
		.code_byte    (code_byte),
		.end_of_image (end_of_image)
	);

endmodule

@@ bench/rle_code_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_code_checker: predicts and checks the code stream of the run encoder
// Watches both channels. It rebuilds the open run from each accepted pixel
// request and compares every accepted code against the oldest expectation.
// ----------------------------------------------------------------------------
module rle_code_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	input  logic                         pixel_stall,
	input  logic [rle_pkg::PIXEL_W-1:0]  pixel,
	input  logic                         last_pixel,
	input  logic                         code_valid,
	input  logic                         code_stall,
	input  logic [rle_pkg::CODE_W-1:0]   code_byte,
	input  logic                         end_of_image,
	output int                           mismatches,
	output int                           outstanding
);
	import rle_pkg::*;

	logic              run_bit_q;
	logic [LEN_W-1:0]  run_len_q;
	code_t             expected_codes [$];

	// Close the open run on a bit change, extend it, then close it when full or last
	task automatic encode_pixel(input logic [PIXEL_W-1:0] p, input logic lp);
		logic  on;
		code_t c;
		on = (p != '0);
		if (run_len_q != '0 && on != run_bit_q) begin
			c.run_bit = run_bit_q;
			c.run_len = run_len_q;
			c.eoi     = 1'b0;
			expected_codes.push_back(c);
			run_len_q = '0;
		end
		if (run_len_q == '0)
			run_bit_q = on;
		run_len_q = run_len_q + LEN_W'(1);
		if (run_len_q >= LEN_W'(MAX_RUN_DEF) || lp) begin
			c.run_bit = run_bit_q;
			c.run_len = run_len_q;
			c.eoi     = lp;
			expected_codes.push_back(c);
			run_len_q = '0;
		end
	endtask

	task automatic check_code();
		code_t want;
		if (expected_codes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: code %02h end_of_image %0b arrived with nothing expected",
					$realtime, code_byte, end_of_image);
			return;
		end
		want = expected_codes.pop_front();
		if (code_byte !== {want.run_bit, want.run_len} || end_of_image !== want.eoi) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: code mismatch, expected %02h eoi %0b, got %02h eoi %0b",
					$realtime, {want.run_bit, want.run_len}, want.eoi,
					code_byte, end_of_image);
		end
	endtask

	// Retire the code first: a code can never stem from the pixel of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bit_q = 1'b0;
			run_len_q = '0;
			expected_codes.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (code_valid && !code_stall)
				check_code();
			if (pixel_valid && !pixel_stall)
				encode_pixel(pixel, last_pixel);
			outstanding = expected_codes.size();
		end
	end

endmodule

@@ bench/bitmap_run_length_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_length_encoder_tb: stimulus and verdict for the run encoder
// Sends directed pixel requests, then random images made of runs plus noise,
// with random idling on both channels; a separate checker scores the codes.
// ----------------------------------------------------------------------------
module bitmap_run_length_encoder_tb;

	import rle_pkg::*;

	localparam int TOTAL_PIXELS = 950;	// random part stops at the first image end past this
	localparam int QUIET_TAIL   = 120;	// last requests run with no idling on either side
	localparam int HOLD_AT      = 300;	// where the long receiver hold-off starts
	localparam int DRAIN_AT     = 600;	// where the sender pauses until every code is taken
	localparam int LONG_HOLD    = 80;	// cycles of the long hold-off
	localparam int HOLD_PIXELS  = 40;	// requests pushed against the hold-off
	localparam int SETTLE       = 16;	// cycles watched after the last code

	logic                clk;
	logic                arst_n;
	logic                pixel_valid;
	logic                pixel_stall;
	logic [PIXEL_W-1:0]  pixel;
	logic                last_pixel;
	logic                code_valid;
	logic                code_stall;
	logic [CODE_W-1:0]   code_byte;
	logic                end_of_image;

	int mismatches;
	int outstanding;

	// Shared between the sender and the receiver processes
	int sent          = 0;
	bit quiet         = 1'b0;
	bit steady        = 1'b0;
	bit long_hold_req = 1'b0;
	bit hold_on       = 1'b0;

	bitmap_run_length_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.last_pixel   (last_pixel),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code_byte    (code_byte),
		.end_of_image (end_of_image)
	);

	rle_code_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.last_pixel   (last_pixel),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code_byte    (code_byte),
		.end_of_image (end_of_image),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one pixel request at the falling edge and hold it until accepted;
	// then, now and again, drop valid for a burst of random length.
	task automatic offer_pixel(input logic [PIXEL_W-1:0] p, input logic lp);
		@(negedge clk);
		pixel_valid <= 1'b1;
		pixel       <= p;
		last_pixel  <= lp;
		do @(posedge clk); while (pixel_stall);
		sent++;
		quiet = (sent >= TOTAL_PIXELS - QUIET_TAIL);
		if (!quiet && !steady && $urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				@(negedge clk);
				pixel_valid <= 1'b0;
			end
		end
	endtask

	// Hold the sender off until every expected code has been taken
	task automatic drain_codes();
		@(negedge clk);
		pixel_valid <= 1'b0;
		wait (outstanding == 0);
	endtask

	// Send one run of identical bits, marking its last pixel if it closes the image
	task automatic send_run(input logic on, input int len, input logic closes_image);
		for (int i = 0; i < len; i++)
			offer_pixel(on ? PIXEL_W'($urandom_range(1, 255)) : '0,
				closes_image && i == len - 1);
	endtask

	// Sender: reset, directed requests, then random images
	initial begin
		int  n_runs;
		int  len;
		int  n;
		logic on;

		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		pixel       = '0;
		last_pixel  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Lone off pixel closing an image, then a lone on pixel
		offer_pixel(8'h00, 1'b1);
		offer_pixel(8'hFF, 1'b1);
		// Any nonzero value counts as on: 01 and 80 share a run, then bit changes
		offer_pixel(8'h01, 1'b0);
		offer_pixel(8'h80, 1'b0);
		offer_pixel(8'h00, 1'b0);
		offer_pixel(8'h00, 1'b0);
		offer_pixel(8'h02, 1'b0);
		offer_pixel(8'h04, 1'b1);
		// Bit change on the last pixel: two codes from a single request
		offer_pixel(8'h00, 1'b0);
		offer_pixel(8'h10, 1'b1);
		// Single-pixel runs walking the remaining pixel bits, with AA and 55 sharing one run
		offer_pixel(8'h08, 1'b0);
		offer_pixel(8'h00, 1'b0);
		offer_pixel(8'h20, 1'b0);
		offer_pixel(8'h00, 1'b0);
		offer_pixel(8'h40, 1'b0);
		offer_pixel(8'hAA, 1'b0);
		offer_pixel(8'h55, 1'b0);
		offer_pixel(8'h00, 1'b1);

		// Pause the sender until the encoder has emptied
		drain_codes();

		while (sent < TOTAL_PIXELS) begin
			if (sent >= HOLD_AT && n_runs == 0) begin
				// Long receiver hold-off: keep pushing alternating pixels, one code
				// each, so the code queue fills and the pixel side stalls
				long_hold_req = 1'b1;
				steady        = 1'b1;
				@(negedge clk);
				pixel_valid <= 1'b0;
				wait (hold_on);
				for (int i = 0; i < HOLD_PIXELS; i++)
					offer_pixel(i[0] ? PIXEL_W'($urandom_range(1, 255)) : '0,
						i == HOLD_PIXELS - 1);
				steady = 1'b0;
				n_runs = -1;	// mark the hold-off as done
			end else if (sent >= DRAIN_AT && n_runs != -2) begin
				drain_codes();
				n_runs = -2;
			end else if ($urandom_range(0, 4) == 0) begin
				// Noise image: pixels of random bits, random length
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					offer_pixel($urandom_range(0, 1) ? PIXEL_W'($urandom_range(1, 255)) : '0,
						i == n - 1);
			end else begin
				// Well-formed image: mostly short runs, now and then full or overfull ones
				n  = $urandom_range(1, 6);
				on = 1'($urandom_range(0, 1));
				for (int r = 0; r < n; r++) begin
					case ($urandom_range(0, 63))
						0:       len = MAX_RUN_DEF;
						1:       len = $urandom_range(MAX_RUN_DEF - 7, MAX_RUN_DEF + 8);
						2:       len = 2 * MAX_RUN_DEF;
						default: len = $urandom_range(1, 8);
					endcase
					// Let the image end exactly on a full run now and then
					if (r == n - 1 && $urandom_range(0, 5) == 0)
						len = MAX_RUN_DEF * $urandom_range(1, 2);
					send_run(on, len, r == n - 1);
					// Mostly alternate; a repeated bit merges into the open run
					if ($urandom_range(0, 4) != 0)
						on = ~on;
				end
			end
		end

		drain_codes();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[bitmap_run_length_encoder] OK");
		else
			$display("[bitmap_run_length_encoder] ERROR");
		$finish;
	end

	// Receiver: stall bursts, calm stretches, and one long hold-off on request
	initial begin
		code_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				code_stall <= 1'b1;
				hold_on = 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_on       = 1'b0;
				long_hold_req = 1'b0;
			end else if (quiet) begin
				code_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						code_stall <= 1'b1;
						repeat ($urandom_range(0, 11)) @(negedge clk);
					end
					2: begin
						code_stall <= 1'b0;
						repeat ($urandom_range(10, 40)) @(negedge clk);
					end
					default: code_stall <= 1'b0;
				endcase
			end
		end
	end

	// Give up on a hung run
	initial begin
		#5ms;
		$display("[bitmap_run_length_encoder] ERROR");
		$finish;
	end

endmodule
